// File: design/brcsi_pkg.sv
package brcsi_pkg;

	localparam int CNT_W = 13;

	typedef enum logic [1:0] {
		MODE_SET    = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_INVERT = 2'd2,
		MODE_WIPE   = 2'd3
	} mode_t;

	typedef struct packed {
		logic load;
		logic wipe;
		logic rd_en;
	} dp_cmd_t;

	typedef struct packed {
		logic col_empty;
	} dp_sts_t;

	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

endpackage

// File: design/bitmap_rect_set_clear_invert.sv
// channel   direction  handshake         fields
// request   in         start & !busy     mode, row_first, col_first, row_last, col_last
// result    out        done (1 cycle)    lit_total
//
// A rectangle request runs from accept to done as the mode and column mask load at
// accept, one row read-modify-write per cycle on the two-port bitmap memory, a flush
// state that drains the popcount pipeline, then the done state.
// Clear all and empty rectangles skip the row sweep; per-row valid flops clear at once.
// Reset is asynchronous and leaves the bitmap empty with no clearing pass.
// The receiver cannot stall; busy holds off new requests until done.
module bitmap_rect_set_clear_invert
	import brcsi_pkg::*;
#(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       mode,
	input  logic [6:0]       row_first,
	input  logic [6:0]       col_first,
	input  logic [6:0]       row_last,
	input  logic [6:0]       col_last,
	output logic             done,
	output logic [CNT_W-1:0] lit_total
);

	localparam int ROW_AW = $clog2(GRID_ROWS);

	dp_cmd_t           cmd;
	dp_sts_t           sts;
	logic [ROW_AW-1:0] rd_row;

	brcsi_ctrl #(
		.GRID_ROWS (GRID_ROWS),
		.ROW_AW    (ROW_AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.row_first (row_first),
		.row_last  (row_last),
		.sts       (sts),
		.cmd       (cmd),
		.rd_row    (rd_row),
		.busy      (busy),
		.done      (done)
	);

	brcsi_dp #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS),
		.ROW_AW    (ROW_AW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_row    (rd_row),
		.mode      (mode),
		.col_first (col_first),
		.col_last  (col_last),
		.sts       (sts),
		.lit_total (lit_total)
	);

endmodule

// File: design/brcsi_ctrl.sv
module brcsi_ctrl
	import brcsi_pkg::*;
#(
	parameter int GRID_ROWS = 64,
	parameter int ROW_AW    = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        mode,
	input  logic [6:0]        row_first,
	input  logic [6:0]        row_last,
	input  dp_sts_t           sts,
	output dp_cmd_t           cmd,
	output logic [ROW_AW-1:0] rd_row,
	output logic              busy,
	output logic              done
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SWEEP = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic              flush_q;
	logic [ROW_AW-1:0] row_q, last_q;
	logic [8:0]        row_last_c;
	logic              accept, wipe, row_empty, empty_cmd;

	assign accept     = start && (state_q == ST_IDLE);
	assign wipe       = (mode_t'(mode) == MODE_WIPE);
	assign row_last_c = ({2'b00, row_last} >= 9'(GRID_ROWS)) ? 9'(GRID_ROWS - 1)
	                                                          : {2'b00, row_last};
	assign row_empty  = ({2'b00, row_first} > row_last_c);
	assign empty_cmd  = wipe || row_empty || sts.col_empty;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = empty_cmd ? ST_DONE : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (row_q == last_q) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (flush_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			flush_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SWEEP) begin
				flush_q <= 1'b0;
			end else if (state_q == ST_FLUSH) begin
				flush_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q  <= ROW_AW'(row_first);
			last_q <= ROW_AW'(row_last_c);
		end else if (state_q == ST_SWEEP) begin
			row_q <= row_q + 1'b1;
		end
	end

	assign cmd.load  = accept && !wipe;
	assign cmd.wipe  = accept && wipe;
	assign cmd.rd_en = (state_q == ST_SWEEP);
	assign rd_row    = row_q;
	assign busy      = (state_q != ST_IDLE);
	assign done      = (state_q == ST_DONE);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	a_wipe_fast: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wipe |=> done) else $error("clear all did not finish next cycle");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && row_q != last_q) |=> (state_q == ST_SWEEP))
		else $error("sweep left before last row");

endmodule

// File: design/brcsi_dp.sv
module brcsi_dp
	import brcsi_pkg::*;
#(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64,
	parameter int ROW_AW    = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [ROW_AW-1:0] rd_row,
	input  logic [1:0]        mode,
	input  logic [6:0]        col_first,
	input  logic [6:0]        col_last,
	output dp_sts_t           sts,
	output logic [CNT_W-1:0]  lit_total
);

	localparam int NGRP  = (GRID_COLS + 7) / 8;
	localparam int PAD_W = NGRP * 8;
	localparam int SUM_W = $clog2(GRID_COLS + 1);

	logic [GRID_COLS-1:0] mem_q [GRID_ROWS];
	logic [GRID_ROWS-1:0] row_vld_q;

	mode_t                mode_q;
	logic [GRID_COLS-1:0] mask_q, mask_d;
	logic [6:0]           col_last_c;

	logic                 act_s1, vld_s1;
	logic [ROW_AW-1:0]    row_s1;
	logic [GRID_COLS-1:0] rdata_s1;
	logic [GRID_COLS-1:0] old_word, new_word;
	logic [PAD_W-1:0]     old_pad, new_pad;

	logic                 act_s2;
	logic [3:0]           old_pop_s2 [NGRP];
	logic [3:0]           new_pop_s2 [NGRP];
	logic [SUM_W-1:0]     old_sum, new_sum;

	logic [CNT_W-1:0]     count_q;

	assign col_last_c = (col_last >= 7'(GRID_COLS)) ? 7'(GRID_COLS - 1) : col_last;
	assign sts.col_empty = (col_first > col_last_c);

	always_comb begin
		for (int c = 0; c < GRID_COLS; c++) begin
			mask_d[c] = (7'(c) >= col_first) && (7'(c) <= col_last_c);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_t'(mode);
			mask_q <= mask_d;
		end
	end

	// one row read-modify-write per cycle
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_s1 <= mem_q[rd_row];
		end
		if (act_s1) begin
			mem_q[row_s1] <= new_word;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= rd_row;
		vld_s1 <= row_vld_q[rd_row];
	end

	assign old_word = vld_s1 ? rdata_s1 : '0;

	always_comb begin
		case (mode_q)
			MODE_SET:    new_word = old_word | mask_q;
			MODE_CLEAR:  new_word = old_word & ~mask_q;
			MODE_INVERT: new_word = old_word ^ mask_q;
			default:     new_word = old_word;
		endcase
	end

	assign old_pad = PAD_W'(old_word);
	assign new_pad = PAD_W'(new_word);

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			old_pop_s2[g] <= pop8(old_pad[g*8 +: 8]);
			new_pop_s2[g] <= pop8(new_pad[g*8 +: 8]);
		end
	end

	always_comb begin
		old_sum = '0;
		new_sum = '0;
		for (int g = 0; g < NGRP; g++) begin
			old_sum = old_sum + SUM_W'(old_pop_s2[g]);
			new_sum = new_sum + SUM_W'(new_pop_s2[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1    <= 1'b0;
			act_s2    <= 1'b0;
			row_vld_q <= '0;
			count_q   <= '0;
		end else begin
			act_s1 <= cmd.rd_en;
			act_s2 <= act_s1;
			if (cmd.wipe) begin
				row_vld_q <= '0;
				count_q   <= '0;
			end else begin
				if (act_s1) begin
					row_vld_q[row_s1] <= 1'b1;
				end
				if (act_s2) begin
					count_q <= count_q + CNT_W'(new_sum) - CNT_W'(old_sum);
				end
			end
		end
	end

	assign lit_total = count_q;

	a_wipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wipe |-> (!act_s1 && !act_s2 && !cmd.rd_en))
		else $error("clear all while rows in flight");

	a_wipe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wipe |=> (count_q == '0 && row_vld_q == '0))
		else $error("clear all left state behind");

	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		act_s2 |-> $past(cmd.rd_en, 2))
		else $error("count update without a row read");

endmodule
